// ----- src/dmxsc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmxsc_pkg
// shared types and constants for the dmx slot capture receiver
// ----------------------------------------------------------------------------
package dmxsc_pkg;

    // capture limits
    localparam int MAX_CHANNELS = 4;
    localparam int CAP_LIMIT    = (MAX_CHANNELS < 7) ? MAX_CHANNELS : 7;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 9;
    localparam int COUNT_W = 3;
    localparam int POS_W   = 10;
    localparam int INDEX_W = 2;

    localparam logic [COUNT_W-1:0] LOAD_CAP = COUNT_W'(CAP_LIMIT);
    localparam logic [POS_W-1:0]   POS_MAX  = {POS_W{1'b1}};

    // configuration register indexes
    localparam logic REG_START_ADDRESS = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    // one captured slot
    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] channel_index;
        logic [BYTE_W-1:0]  channel_value;
        logic               frame_done;
    } slot_result_t;

endpackage

// ----- src/dmxsc_slot_track.sv -----
// ----------------------------------------------------------------------------
// dmxsc_slot_track
// break / start code tracking, slot counting and capture window
// ----------------------------------------------------------------------------
module dmxsc_slot_track (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          beat_accept,
    input  logic [dmxsc_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                          framing_error,
    input  logic                          overrun,
    input  logic [dmxsc_pkg::ADDR_W-1:0]  start_address,
    input  logic [dmxsc_pkg::COUNT_W-1:0] channel_count,
    output dmxsc_pkg::slot_result_t       result
);

    logic                          awaiting_reg, awaiting_next;
    logic [dmxsc_pkg::BYTE_W-1:0]  start_code_reg, start_code_next;
    logic [dmxsc_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [dmxsc_pkg::COUNT_W-1:0] remain_reg, remain_next;
    logic [dmxsc_pkg::INDEX_W-1:0] offset_reg, offset_next;

    logic                          match;
    logic [dmxsc_pkg::COUNT_W-1:0] load_count;
    logic [dmxsc_pkg::COUNT_W-1:0] remain_eff;
    logic [dmxsc_pkg::INDEX_W-1:0] offset_eff;

    assign load_count = (channel_count > dmxsc_pkg::LOAD_CAP) ? dmxsc_pkg::LOAD_CAP
                                                              : channel_count;
    assign match = (start_address != '0) && (pos_reg == {1'b0, start_address});
    assign remain_eff = match ? load_count : remain_reg;
    assign offset_eff = match ? '0 : offset_reg;

    always_comb begin
        awaiting_next   = awaiting_reg;
        start_code_next = start_code_reg;
        pos_next        = pos_reg;
        remain_next     = remain_reg;
        offset_next     = offset_reg;
        result          = '0;
        if (beat_accept && !overrun) begin
            if (framing_error) begin
                awaiting_next = 1'b1;
            end else if (awaiting_reg) begin
                awaiting_next   = 1'b0;
                start_code_next = rx_byte;
                pos_next        = dmxsc_pkg::POS_W'(1);
            end else if (start_code_reg == '0) begin
                remain_next = remain_eff;
                offset_next = offset_eff;
                if (remain_eff != '0) begin
                    remain_next          = remain_eff - 1'b1;
                    offset_next          = offset_eff + 1'b1;
                    result.valid         = 1'b1;
                    result.channel_index = offset_eff;
                    result.channel_value = rx_byte;
                    result.frame_done    = (remain_eff == dmxsc_pkg::COUNT_W'(1));
                end
                if (pos_reg != dmxsc_pkg::POS_MAX) begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg   <= 1'b1;
            start_code_reg <= '0;
            pos_reg        <= '0;
            remain_reg     <= '0;
            offset_reg     <= '0;
        end else begin
            awaiting_reg   <= awaiting_next;
            start_code_reg <= start_code_next;
            pos_reg        <= pos_next;
            remain_reg     <= remain_next;
            offset_reg     <= offset_next;
        end
    end

endmodule

// ----- src/dmx_slot_capture_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// dmx_slot_capture_receiver_unit
// captures a window of dmx512 slots from a stream of received uart characters
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_*       in   tdata: rx_byte; tuser: framing_error, overrun
//  m_*       out  tdata: channel_index, channel_value; tlast: frame_done
//  cfg_*     in   cfg_addr 0 start_address, 1 channel_count
//
//  one character per cycle while s_tready is high; state updates in the cycle a beat is accepted
//  each captured slot is registered into the m_* output register (or the skid entry) from its input beat
//  a two-entry output (register plus skid) lets input flow while m_ stalls;
//  s_tready drops only when both entries hold results
//  aresetn is synchronous, active low; resets tracking state and config
// ----------------------------------------------------------------------------
module dmx_slot_capture_receiver_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input characters
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [0] framing_error, [1] overrun
    // captured slots
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] channel_index, [9:2] channel_value, rest zero
    output logic        m_tlast,   // frame_done
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [8:0]  cfg_wdata
);

    // configuration registers
    logic [dmxsc_pkg::ADDR_W-1:0]  start_address_reg;
    logic [dmxsc_pkg::COUNT_W-1:0] channel_count_reg;

    // output register and skid entry
    dmxsc_pkg::slot_result_t out_reg, out_next;
    dmxsc_pkg::slot_result_t skid_reg, skid_next;

    dmxsc_pkg::slot_result_t result;
    logic                    s_accept;
    logic                    m_accept;

    // input is held back only when the skid entry is occupied
    assign s_tready = !skid_reg.valid;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = out_reg.valid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_address_reg <= '0;
            channel_count_reg <= dmxsc_pkg::COUNT_W'(4);
        end else if (cfg_we) begin
            case (cfg_addr)
                dmxsc_pkg::REG_START_ADDRESS: start_address_reg <= cfg_wdata;
                dmxsc_pkg::REG_CHANNEL_COUNT:
                    channel_count_reg <= cfg_wdata[dmxsc_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    dmxsc_slot_track u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .beat_accept   (s_accept),
        .rx_byte       (s_tdata),
        .framing_error (s_tuser[0]),
        .overrun       (s_tuser[1]),
        .start_address (start_address_reg),
        .channel_count (channel_count_reg),
        .result        (result)
    );

    // output staging: new result goes to the output register when it frees,
    // otherwise parks in the skid entry
    always_comb begin
        out_next  = out_reg;
        skid_next = skid_reg;
        if (skid_reg.valid) begin
            if (m_accept) begin
                out_next       = skid_reg;
                skid_next.valid = 1'b0;
            end
        end else if (result.valid) begin
            if (!out_reg.valid || m_accept) begin
                out_next = result;
            end else begin
                skid_next = result;
            end
        end else if (m_accept) begin
            out_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid  <= 1'b0;
            skid_reg.valid <= 1'b0;
        end else begin
            out_reg.valid  <= out_next.valid;
            skid_reg.valid <= skid_next.valid;
        end
        out_reg.channel_index  <= out_next.channel_index;
        out_reg.channel_value  <= out_next.channel_value;
        out_reg.frame_done     <= out_next.frame_done;
        skid_reg.channel_index <= skid_next.channel_index;
        skid_reg.channel_value <= skid_next.channel_value;
        skid_reg.frame_done    <= skid_next.frame_done;
    end

    assign m_tvalid = out_reg.valid;
    assign m_tdata  = {6'b0, out_reg.channel_value, out_reg.channel_index};
    assign m_tlast  = out_reg.frame_done;

`ifndef ASSERT_OFF
    // skid entry is only ever filled behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_reg.valid |-> out_reg.valid)
        else $error("skid entry valid with empty output register");

    // a result arriving while the output stalls must land in the skid entry
    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.valid && out_reg.valid && !m_tready) |=> skid_reg.valid)
        else $error("result lost while output stalled");

    // draining the skid entry moves it forward and frees input
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_reg.valid && m_tready) |=> (out_reg.valid && !skid_reg.valid))
        else $error("skid entry not drained into output register");

    // no result without an accepted input beat
    a_result_needs_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> s_accept)
        else $error("result produced without an accepted beat");
`endif

endmodule
